[rtl/rbfa_pkg.sv]
// Shared constants, types and codes for the region bump frame allocator.
// Depends on nothing; rbfa_region_calc, the top level and the testbench import it.
package rbfa_pkg;

  localparam int unsigned FRAME_BYTES = 4096;
  localparam int unsigned MAX_REGIONS = 32;

  localparam int unsigned ADDR_W      = 64;
  localparam int unsigned CNT_W       = 52;
  localparam int unsigned FRAME_SHIFT = $clog2(FRAME_BYTES);
  localparam int unsigned FN_W        = ADDR_W - FRAME_SHIFT;
  localparam int unsigned REG_CNT_W   = $clog2(MAX_REGIONS + 1);
  localparam int unsigned IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned SUM_W       = ((FN_W > CNT_W) ? FN_W : CNT_W) + 1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_ALLOC  = 2'd2
  } action_e;

  // One region table entry; addresses are held as frame numbers.
  typedef struct packed {
    logic            valid;
    logic [FN_W-1:0] first_fn;
    logic [FN_W-1:0] limit_fn;
  } region_t;

  localparam int unsigned ENTRY_W = $bits(region_t);

endpackage

[rtl/rbfa_region_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing; holds the region table of the allocator.
module rbfa_region_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rbfa_region_calc.sv]
// Region geometry unit: registers the aligned first frame and limit of an appended
// region, then derives its validity and frame count. Depends on rbfa_pkg.
module rbfa_region_calc import rbfa_pkg::*; (
  input  logic              clk_i,
  input  logic              load_i,
  input  logic [ADDR_W-1:0] region_base_i,
  input  logic [ADDR_W-1:0] region_length_i,
  input  logic              region_usable_i,
  output region_t           region_o,
  output logic [FN_W-1:0]   count_o
);

  logic [FN_W-1:0] first_fn_d, first_fn_q;
  logic [FN_W-1:0] limit_fn_d, limit_fn_q;
  logic            wrap_d, wrap_q;
  logic            usable_q;
  logic [FN_W-1:0] base_fn;
  logic            base_off;
  logic [ADDR_W:0] end_sum;

  always_comb begin
    base_fn    = region_base_i[ADDR_W-1:FRAME_SHIFT];
    base_off   = |region_base_i[FRAME_SHIFT-1:0];
    wrap_d     = base_off && (&base_fn);
    first_fn_d = base_off ? base_fn + FN_W'(1) : base_fn;
    if (first_fn_d == '0) begin
      first_fn_d = FN_W'(1);
    end
    end_sum    = {1'b0, region_base_i} + {1'b0, region_length_i};
    limit_fn_d = end_sum[ADDR_W] ? {FN_W{1'b1}} : end_sum[ADDR_W-1:FRAME_SHIFT];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      first_fn_q <= first_fn_d;
      limit_fn_q <= limit_fn_d;
      wrap_q     <= wrap_d;
      usable_q   <= region_usable_i;
    end
  end

  always_comb begin
    region_o.valid    = usable_q && !wrap_q && (limit_fn_q > first_fn_q);
    region_o.first_fn = first_fn_q;
    region_o.limit_fn = limit_fn_q;
    count_o           = limit_fn_q - first_fn_q;
  end

endmodule

[rtl/region_bump_frame_allocator.sv]
// Top level of the region bump frame allocator: control sequencer and statistics.
// Depends on rbfa_pkg, rbfa_region_calc and rbfa_region_ram.
//
// Items arrive on a valid/ready input channel and each produces exactly one
// result beat on a valid/ready output channel. Action clear empties the region
// table and zeroes the counters, append stores one region while the table has
// room, allocate hands out the next free frame. The region table lives in a
// synchronous RAM. Clear, an unknown action and an append to a full table go
// straight to the done state; an append passes through a write state first;
// an allocation alternates a RAM read state and a check state for each region
// visited until it finds a frame or runs out of regions, then goes to done.
// One item is processed at a time; the next beat is taken as soon as the
// result has been written to the output register, even if that result has
// not yet been taken. When the receiver stalls, one more item is taken and
// worked through, after which its result waits inside the block and no
// further input beat is accepted.
// After reset the table is empty, all counters are zero and no result is
// pending; the RAM contents are undefined and are never read before written.
module region_bump_frame_allocator import rbfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [ADDR_W-1:0] region_base_i,
  input  logic [ADDR_W-1:0] region_length_i,
  input  logic              region_usable_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              ok_o,
  output logic [ADDR_W-1:0] frame_address_o,
  output logic [CNT_W-1:0]  total_frames_o,
  output logic [CNT_W-1:0]  allocated_frames_o,
  output logic [CNT_W-1:0]  free_frames_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND_WRITE,
    ST_ALLOC_READ,
    ST_ALLOC_CHECK,
    ST_DONE
  } state_e;

  state_e                 state_d, state_q;
  logic [REG_CNT_W-1:0]   region_total_d, region_total_q;
  logic [REG_CNT_W-1:0]   walk_pos_d, walk_pos_q;
  logic [FN_W-1:0]        next_fn_d, next_fn_q;
  logic [CNT_W-1:0]       frame_sum_d, frame_sum_q;
  logic [CNT_W-1:0]       handed_out_d, handed_out_q;
  logic                   pend_ok_d, pend_ok_q;
  logic [FN_W-1:0]        pend_fn_d, pend_fn_q;
  logic                   out_valid_d, out_valid_q;
  logic                   ok_d, ok_q;
  logic [ADDR_W-1:0]      frame_address_d, frame_address_q;
  logic [CNT_W-1:0]       total_frames_d, total_frames_q;
  logic [CNT_W-1:0]       allocated_frames_d, allocated_frames_q;
  logic [CNT_W-1:0]       free_frames_d, free_frames_q;

  logic                   calc_load;
  region_t                calc_region;
  logic [FN_W-1:0]        calc_count;
  logic                   ram_we;
  logic                   ram_re;
  logic [ENTRY_W-1:0]     ram_rdata;
  region_t                rd_entry;
  logic [FN_W-1:0]        cand_fn;
  logic                   hit;
  logic [SUM_W-1:0]       sum_ext;

  assign in_ready_o = (state_q == ST_IDLE);
  assign calc_load  = in_valid_i && in_ready_o && (action_i == ACT_APPEND);

  rbfa_region_calc u_calc (
    .clk_i           (clk_i),
    .load_i          (calc_load),
    .region_base_i   (region_base_i),
    .region_length_i (region_length_i),
    .region_usable_i (region_usable_i),
    .region_o        (calc_region),
    .count_o         (calc_count)
  );

  rbfa_region_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_REGIONS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (region_total_q[IDX_W-1:0]),
    .wdata_i (calc_region),
    .re_i    (ram_re),
    .raddr_i (walk_pos_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    rd_entry = region_t'(ram_rdata);
    cand_fn  = ((next_fn_q == '0) || (next_fn_q < rd_entry.first_fn)) ?
               rd_entry.first_fn : next_fn_q;
    hit      = rd_entry.valid && (cand_fn < rd_entry.limit_fn);
    sum_ext  = SUM_W'(frame_sum_q) + SUM_W'(calc_count);
  end

  always_comb begin
    state_d            = state_q;
    region_total_d     = region_total_q;
    walk_pos_d         = walk_pos_q;
    next_fn_d          = next_fn_q;
    frame_sum_d        = frame_sum_q;
    handed_out_d       = handed_out_q;
    pend_ok_d          = pend_ok_q;
    pend_fn_d          = pend_fn_q;
    out_valid_d        = out_valid_q;
    ok_d               = ok_q;
    frame_address_d    = frame_address_q;
    total_frames_d     = total_frames_q;
    allocated_frames_d = allocated_frames_q;
    free_frames_d      = free_frames_q;
    ram_we             = 1'b0;
    ram_re             = 1'b0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pend_ok_d = 1'b0;
          pend_fn_d = '0;
          state_d   = ST_DONE;
          unique case (action_i)
            ACT_CLEAR: begin
              region_total_d = '0;
              walk_pos_d     = '0;
              next_fn_d      = '0;
              frame_sum_d    = '0;
              handed_out_d   = '0;
              pend_ok_d      = 1'b1;
            end
            ACT_APPEND: begin
              if (region_total_q < REG_CNT_W'(MAX_REGIONS)) begin
                state_d = ST_APPEND_WRITE;
              end
            end
            ACT_ALLOC: begin
              state_d = ST_ALLOC_READ;
            end
            default: begin
              pend_ok_d = 1'b0;
            end
          endcase
        end
      end
      ST_APPEND_WRITE: begin
        ram_we         = 1'b1;
        region_total_d = region_total_q + REG_CNT_W'(1);
        pend_ok_d      = 1'b1;
        if (calc_region.valid) begin
          frame_sum_d = (sum_ext > SUM_W'(CNT_MAX)) ? CNT_MAX : sum_ext[CNT_W-1:0];
        end
        state_d = ST_DONE;
      end
      ST_ALLOC_READ: begin
        if (walk_pos_q < region_total_q) begin
          ram_re  = 1'b1;
          state_d = ST_ALLOC_CHECK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ALLOC_CHECK: begin
        if (hit) begin
          pend_ok_d = 1'b1;
          pend_fn_d = cand_fn;
          next_fn_d = cand_fn + FN_W'(1);
          if (handed_out_q != CNT_MAX) begin
            handed_out_d = handed_out_q + CNT_W'(1);
          end
          state_d = ST_DONE;
        end else begin
          walk_pos_d = walk_pos_q + REG_CNT_W'(1);
          next_fn_d  = '0;
          state_d    = ST_ALLOC_READ;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          ok_d               = pend_ok_q;
          frame_address_d    = {pend_fn_q, {FRAME_SHIFT{1'b0}}};
          total_frames_d     = frame_sum_q;
          allocated_frames_d = handed_out_q;
          free_frames_d      = (frame_sum_q > handed_out_q) ?
                               frame_sum_q - handed_out_q : '0;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_IDLE;
      region_total_q     <= '0;
      walk_pos_q         <= '0;
      next_fn_q          <= '0;
      frame_sum_q        <= '0;
      handed_out_q       <= '0;
      pend_ok_q          <= 1'b0;
      pend_fn_q          <= '0;
      out_valid_q        <= 1'b0;
      ok_q               <= 1'b0;
      frame_address_q    <= '0;
      total_frames_q     <= '0;
      allocated_frames_q <= '0;
      free_frames_q      <= '0;
    end else begin
      state_q            <= state_d;
      region_total_q     <= region_total_d;
      walk_pos_q         <= walk_pos_d;
      next_fn_q          <= next_fn_d;
      frame_sum_q        <= frame_sum_d;
      handed_out_q       <= handed_out_d;
      pend_ok_q          <= pend_ok_d;
      pend_fn_q          <= pend_fn_d;
      out_valid_q        <= out_valid_d;
      ok_q               <= ok_d;
      frame_address_q    <= frame_address_d;
      total_frames_q     <= total_frames_d;
      allocated_frames_q <= allocated_frames_d;
      free_frames_q      <= free_frames_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign ok_o               = ok_q;
  assign frame_address_o    = frame_address_q;
  assign total_frames_o     = total_frames_q;
  assign allocated_frames_o = allocated_frames_q;
  assign free_frames_o      = free_frames_q;

`ifndef NO_ASSERTIONS
  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_pos_q <= region_total_q)
    else $error("Walk position has passed the end of the region table.");

  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    region_total_q <= REG_CNT_W'(MAX_REGIONS))
    else $error("Region count exceeds the table depth.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("A second beat was accepted before the first one finished.");

  a_ram_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("Region table written and read in the same cycle.");

  a_fail_no_address: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (frame_address_o == '0))
    else $error("A failed result carries a frame address.");
`endif

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the region bump frame allocator.
// Depends on rbfa_pkg and region_bump_frame_allocator; predicts every result beat
// from its own copy of the region table and compares it field by field.
module tb_top import rbfa_pkg::*; ();

  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam logic [ADDR_W-1:0] FRAME = 64'(FRAME_BYTES);
  localparam logic [ADDR_W-1:0] FMASK = FRAME - 64'd1;
  localparam logic [ADDR_W-1:0] CNT_TOP = 64'(CNT_MAX);
  localparam int ITEM_TARGET = 1500;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  spare;
  } alloc_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        action_i = ACT_CLEAR;
  logic [ADDR_W-1:0] region_base_i = '0;
  logic [ADDR_W-1:0] region_length_i = '0;
  logic              region_usable_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              ok_o;
  logic [ADDR_W-1:0] frame_address_o;
  logic [CNT_W-1:0]  total_frames_o;
  logic [CNT_W-1:0]  allocated_frames_o;
  logic [CNT_W-1:0]  free_frames_o;

  // Predicted allocator state.
  logic [ADDR_W-1:0] first_fr [MAX_REGIONS];
  logic [ADDR_W-1:0] limit_fr [MAX_REGIONS];
  logic              region_ok [MAX_REGIONS];
  int unsigned       regions_used = 0;
  int unsigned       walk_idx = 0;
  logic [ADDR_W-1:0] bump_addr = '0;
  logic [ADDR_W-1:0] total_cnt = '0;
  logic [ADDR_W-1:0] given_cnt = '0;

  alloc_result_t pending_results[$];
  alloc_result_t head;
  int  mismatches = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  int  hold_request = 0;
  int  hold_left = 0;
  bit  idling_on = 1'b1;

  region_bump_frame_allocator uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .action_i           (action_i),
    .region_base_i      (region_base_i),
    .region_length_i    (region_length_i),
    .region_usable_i    (region_usable_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .ok_o               (ok_o),
    .frame_address_o    (frame_address_o),
    .total_frames_o     (total_frames_o),
    .allocated_frames_o (allocated_frames_o),
    .free_frames_o      (free_frames_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic alloc_result_t next_allocator_result(logic [1:0] act,
      logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] len, logic usable);
    alloc_result_t r;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] e;
    logic [ADDR_W-1:0] n;
    logic wrap;
    logic v;
    logic found;
    r = '0;
    case (act)
      ACT_CLEAR: begin
        regions_used = 0;
        walk_idx = 0;
        bump_addr = '0;
        total_cnt = '0;
        given_cnt = '0;
        r.ok = 1'b1;
      end
      ACT_APPEND: begin
        if (regions_used < MAX_REGIONS) begin
          wrap = 1'b0;
          s = base;
          if ((base & FMASK) != '0) begin
            if (base > ~FMASK) wrap = 1'b1;
            else s = (base + FMASK) & ~FMASK;
          end
          if (s < FRAME) s = FRAME;
          if (wrap) s = '0;
          e = base + len;
          if (e < base) e = '1;
          e = e & ~FMASK;
          v = usable && (s != '0) && (e > s);
          first_fr[regions_used] = s;
          limit_fr[regions_used] = e;
          region_ok[regions_used] = v;
          if (v) begin
            n = (e - s) / FRAME;
            if (n > CNT_TOP - total_cnt) total_cnt = CNT_TOP;
            else total_cnt = total_cnt + n;
          end
          regions_used++;
          r.ok = 1'b1;
        end
      end
      ACT_ALLOC: begin
        found = 1'b0;
        while (!found && walk_idx < regions_used) begin
          if (region_ok[walk_idx]) begin
            if (bump_addr == '0 || bump_addr < first_fr[walk_idx]) begin
              bump_addr = first_fr[walk_idx];
            end
            if (bump_addr <= limit_fr[walk_idx] - FRAME) begin
              r.addr = bump_addr;
              bump_addr = bump_addr + FRAME;
              if (given_cnt < CNT_TOP) given_cnt++;
              r.ok = 1'b1;
              found = 1'b1;
            end
          end
          if (!found) begin
            walk_idx++;
            bump_addr = '0;
          end
        end
      end
      default: begin
      end
    endcase
    r.total = total_cnt[CNT_W-1:0];
    r.used = given_cnt[CNT_W-1:0];
    r.spare = (total_cnt > given_cnt) ? CNT_W'(total_cnt - given_cnt) : '0;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] pick_base();
    case ($urandom_range(0, 11))
      0: return rand64();
      1: return 64'($urandom_range(0, 3 * FRAME_BYTES));
      2: return ~64'($urandom_range(0, 3 * FRAME_BYTES));
      default: return 64'($urandom_range(1, 1 << 20)) * FRAME +
                      (($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, FRAME_BYTES - 1)) : '0);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_length();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return rand64();
      default: return 64'($urandom_range(0, 10)) * FRAME +
                      (($urandom_range(0, 1) == 0) ? 64'($urandom_range(0, FRAME_BYTES - 1)) : '0);
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the beat was taken.
  task automatic send_item(input logic [1:0] act, input logic [ADDR_W-1:0] base,
      input logic [ADDR_W-1:0] len, input logic usable);
    int gap;
    gap = (idling_on && $urandom_range(0, 99) < 9) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    region_base_i <= base;
    region_length_i <= len;
    region_usable_i <= usable;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(next_allocator_result(act, base, len, usable));
    items_sent++;
  endtask

  task automatic send_alloc();
    send_item(ACT_ALLOC, rand64(), rand64(), 1'($urandom));
  endtask

  task automatic append_random();
    send_item(ACT_APPEND, pick_base(), pick_length(), $urandom_range(0, 99) < 85);
  endtask

  task automatic run_sequence();
    int n_app;
    int n_ops;
    int r;
    if ($urandom_range(0, 7) != 0) send_item(ACT_CLEAR, rand64(), rand64(), 1'($urandom));
    n_app = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 6);
    repeat (n_app) append_random();
    n_ops = $urandom_range(5, 40);
    repeat (n_ops) begin
      r = $urandom_range(0, 99);
      if (r < 75) send_alloc();
      else if (r < 92) append_random();
      else if (r < 96) send_item(ACT_UNKNOWN, rand64(), rand64(), 1'($urandom));
      else send_item(ACT_CLEAR, rand64(), rand64(), 1'($urandom));
    end
  endtask

  task automatic test_directed();
    send_alloc();
    send_item(ACT_UNKNOWN, '1, '1, 1'b1);
    send_item(ACT_CLEAR, '0, '0, 1'b0);
    send_item(ACT_APPEND, '0, 3 * FRAME, 1'b1);
    send_item(ACT_APPEND, 64'h1001, 64'h5000, 1'b1);
    send_item(ACT_APPEND, 64'h10_0000, 64'h8000, 1'b0);
    send_item(ACT_APPEND, 64'hFFFF_FFFF_FFFF_F001, 64'h10, 1'b1);
    send_item(ACT_APPEND, 64'h20_0000, '0, 1'b1);
    send_item(ACT_APPEND, 64'hFFFF_FFFF_FFFF_F000, '1, 1'b1);
    repeat (8) send_alloc();
    send_item(ACT_APPEND, 64'h40_0000, 2 * FRAME, 1'b1);
    repeat (3) send_alloc();
    send_item(ACT_CLEAR, '1, '1, 1'b1);
    send_item(ACT_APPEND, '0, '1, 1'b1);
    send_item(ACT_APPEND, '0, '1, 1'b1);
    send_alloc();
    send_item(ACT_UNKNOWN, '0, '0, 1'b0);
  endtask

  task automatic test_full_table();
    send_item(ACT_CLEAR, '0, '0, 1'b0);
    repeat (MAX_REGIONS + 3) append_random();
    repeat (60) send_alloc();
  endtask

  task automatic test_backpressure();
    hold_request = 400;
    send_item(ACT_CLEAR, '0, '0, 1'b0);
    repeat (4) send_item(ACT_APPEND, pick_base() & ~(64'd1 << 63), 4 * FRAME, 1'b1);
    repeat (12) send_alloc();
  endtask

  task automatic test_back_to_back();
    idling_on = 1'b0;
    repeat (8) run_sequence();
    idling_on = 1'b1;
  endtask

  task automatic test_random();
    while (items_sent < ITEM_TARGET) run_sequence();
  endtask

  task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] got,
      input logic [ADDR_W-1:0] want);
    if (mismatches < 40) begin
      $display("mismatch in %s: got %h, expected %h", field, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 64'(ok_o), '0);
      end else begin
        head = pending_results.pop_front();
        if (ok_o !== head.ok) report_mismatch("ok", 64'(ok_o), 64'(head.ok));
        if (frame_address_o !== head.addr) begin
          report_mismatch("frame_address", frame_address_o, head.addr);
        end
        if (total_frames_o !== head.total) begin
          report_mismatch("total_frames", 64'(total_frames_o), 64'(head.total));
        end
        if (allocated_frames_o !== head.used) begin
          report_mismatch("allocated_frames", 64'(allocated_frames_o), 64'(head.used));
        end
        if (free_frames_o !== head.spare) begin
          report_mismatch("free_frames", 64'(free_frames_o), 64'(head.spare));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(idling_on && $urandom_range(0, 99) < 9);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("region_bump_frame_allocator test failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_full_table();
    test_backpressure();
    test_back_to_back();
    test_random();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("region_bump_frame_allocator test passed");
    end else begin
      $display("region_bump_frame_allocator test failed");
    end
    $finish;
  end

endmodule

[region_bump_frame_allocator.f]
rtl/rbfa_pkg.sv
rtl/rbfa_region_ram.sv
rtl/rbfa_region_calc.sv
rtl/region_bump_frame_allocator.sv
tb/tb_top.sv
